/* hw/rtl/kgor_pkg.sv */
// ----------------------------------------------------------------------------
// kgor_pkg
// Shared types and constants for the group order reverser.
// ----------------------------------------------------------------------------
package kgor_pkg;

  // group size register
  localparam int unsigned CfgW        = 5;
  localparam logic [4:0]  GroupSizeRst = 5'd1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic store;   // input request taken, write it into the group store
    logic load;    // move next result from the store into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go;      // the request being stored completes a group or a list
    logic stall;   // output register full and not being taken
    logic final_rd; // the result being loaded is the last of the run
  } status_t;

endpackage

/* hw/rtl/kgor_ctrl.sv */
// ----------------------------------------------------------------------------
// kgor_ctrl
// Controller: takes requests while idle, sequences the drain of a run.
// ----------------------------------------------------------------------------
module kgor_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kgor_pkg::status_t status_i,
  output kgor_pkg::cmd_t    cmd_o
);

  kgor_pkg::state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.store   = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      kgor_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
        if (in_valid_i && status_i.go) begin
          state_d = kgor_pkg::ST_DRAIN;
        end
      end
      kgor_pkg::ST_DRAIN: begin
        cmd_o.load = !status_i.stall;
        if (!status_i.stall && status_i.final_rd) begin
          state_d = kgor_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kgor_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kgor_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/kgor_datapath.sv */
// ----------------------------------------------------------------------------
// kgor_datapath
// Group store, fill and drain counters, group size register, output register.
// ----------------------------------------------------------------------------
module kgor_datapath #(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kgor_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic [VALUE_WIDTH-1:0]       in_value_i,
  input  logic                         in_end_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [VALUE_WIDTH-1:0]       out_value_o,
  output logic                         out_last_o,
  output logic                         out_done_o,
  input  kgor_pkg::cmd_t               cmd_i,
  output kgor_pkg::status_t            status_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned KW   = (CntW > kgor_pkg::CfgW) ? CntW : kgor_pkg::CfgW;

  logic [VALUE_WIDTH-1:0]    store_mem [MAX_GROUP];
  logic [kgor_pkg::CfgW-1:0] gsize_q;
  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           run_n_q;
  logic [CntW-1:0]           cnt_q;
  logic                      rev_q;
  logic                      ends_q;
  logic                      out_valid_q;
  logic [VALUE_WIDTH-1:0]    out_value_q;
  logic                      out_last_q;
  logic                      out_done_q;

  logic [KW-1:0]   k_eff;
  logic            room;
  logic            is_full_grp;
  logic [CntW-1:0] rd_pos;
  logic            rd_last;

  // effective group size: zero acts as one, saturate at the store depth
  always_comb begin
    k_eff = KW'(gsize_q);
    if (gsize_q == '0) begin
      k_eff = KW'(1);
    end else if (KW'(gsize_q) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end
  end

  assign room        = (fill_q < CntW'(MAX_GROUP));
  assign fill_d      = room ? fill_q + CntW'(1) : fill_q;
  assign is_full_grp = (KW'(fill_d) >= k_eff);

  assign rd_pos  = rev_q ? (run_n_q - CntW'(1) - cnt_q) : cnt_q;
  assign rd_last = (cnt_q == run_n_q - CntW'(1));

  assign status_o.go       = is_full_grp || in_end_i;
  assign status_o.stall    = out_valid_q && !out_ready_i;
  assign status_o.final_rd = rd_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && room) begin
      store_mem[fill_q[IdxW-1:0]] <= in_value_i;
    end
    if (cmd_i.load) begin
      out_value_q <= store_mem[rd_pos[IdxW-1:0]];
      out_last_q  <= rd_last;
      out_done_q  <= rd_last && ends_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q     <= kgor_pkg::GroupSizeRst;
      fill_q      <= '0;
      run_n_q     <= '0;
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      ends_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gsize_q <= cfg_wdata_i;
      end
      if (cmd_i.store) begin
        if (status_o.go) begin
          fill_q  <= '0;
          run_n_q <= fill_d;
          cnt_q   <= '0;
          rev_q   <= is_full_grp;
          ends_q  <= in_end_i;
        end else begin
          fill_q <= fill_d;
        end
      end
      if (cmd_i.load) begin
        cnt_q       <= cnt_q + CntW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

/* hw/rtl/k_group_order_reverser_unit.sv */
// ----------------------------------------------------------------------------
// k_group_order_reverser_unit
// Reverses a stream of list elements in groups of a configurable size.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: elem_value, tlast: list_end
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_value, tlast: run_last,
//                                              tuser: list_done
//  cfg       in   cfg_we_i                     cfg_wdata_i: group_size
//
// A request that completes neither a group nor a list is only stored. One
// that completes a run of n elements is stored, and then the run is drained
// from the group store one result a cycle through the registered store read,
// and input is refused meanwhile. The next request is taken while the last
// result of a run still waits in the output register. Output stalls hold the
// drain. Reset clears the fill count and sets the group size to one; the
// store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module k_group_order_reverser_unit #(
  parameter int unsigned MAX_GROUP   = 16,
  parameter int unsigned VALUE_WIDTH = 16,
  // tdata rounded up to whole bytes
  localparam int unsigned DataW      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // group size register
  input  logic                      cfg_we_i,
  input  logic [kgor_pkg::CfgW-1:0] cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [DataW-1:0]          s_axis_tdata,  // [VALUE_WIDTH-1:0] elem_value
  input  logic                      s_axis_tlast,  // list_end
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [DataW-1:0]          m_axis_tdata,  // [VALUE_WIDTH-1:0] out_value
  output logic                      m_axis_tlast,  // run_last
  output logic                      m_axis_tuser   // [0] list_done
);

  kgor_pkg::cmd_t    cmd;
  kgor_pkg::status_t status;
  logic [VALUE_WIDTH-1:0] out_value;

  kgor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kgor_datapath #(
    .MAX_GROUP   (MAX_GROUP),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_value_i  (s_axis_tdata[VALUE_WIDTH-1:0]),
    .in_end_i    (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // zero padding above the value
  assign m_axis_tdata = DataW'(out_value);

endmodule

/* tb/sv/k_group_order_reverser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_group_order_reverser_unit_tb
// Self-checking bench for the group order reverser. A small class predicts
// the reordered stream from every accepted input request and checks each
// output request against it. Plain tasks drive lists of random values,
// rewrite the group size between phases (mid-list too) and insert random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module k_group_order_reverser_unit_tb;

  localparam int unsigned MaxGroup  = 16;
  localparam int unsigned CycleCap  = 200000;
  localparam int unsigned RandReqs  = 200;
  localparam int unsigned SettleCyc = 4;    // settle time before a group size write

  // one predicted output request
  typedef struct {
    logic [15:0] value;
    logic        run_end;
    logic        list_end;
  } order_item_t;

  // --------------------------------------------------------------------------
  // predictor and checker
  // --------------------------------------------------------------------------
  class group_reversal_model;
    logic [15:0]       held_vals [MaxGroup];
    int unsigned       held_cnt;
    logic [4:0]        size_reg;
    order_item_t       due_results[$];
    int unsigned       fails;

    function new();
      held_cnt = 0;
      size_reg = kgor_pkg::GroupSizeRst;
      fails    = 0;
    endfunction

    function void set_group_size(logic [4:0] v);
      size_reg = v;
    endfunction

    // an accepted input request: store it, release a run if one completes
    function void note_request(logic [15:0] v, logic ends);
      int unsigned k;
      int unsigned n;
      order_item_t r;
      k = (size_reg == 0) ? 1 : ((size_reg > MaxGroup) ? MaxGroup : int'(size_reg));
      if (held_cnt < MaxGroup) begin
        held_vals[held_cnt] = v;
        held_cnt++;
      end
      n = held_cnt;
      if (n >= k) begin
        // complete group (or more, after the size was lowered): reversed
        for (int unsigned i = 0; i < n; i++) begin
          r.value    = held_vals[n - 1 - i];
          r.run_end  = (i + 1 == n);
          r.list_end = (i + 1 == n) && ends;
          due_results.push_back(r);
        end
        held_cnt = 0;
      end else if (ends) begin
        // list ended on a partial group: original order
        for (int unsigned i = 0; i < n; i++) begin
          r.value    = held_vals[i];
          r.run_end  = (i + 1 == n);
          r.list_end = (i + 1 == n);
          due_results.push_back(r);
        end
        held_cnt = 0;
      end
    endfunction

    function void check_result(logic [15:0] v, logic run_end, logic list_end);
      order_item_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected output: expected none, got value %h last %b done %b",
                 $time, v, run_end, list_end);
        fails++;
        return;
      end
      e = due_results.pop_front();
      if (v !== e.value) begin
        $display("%0t: out_value mismatch: expected %h, got %h", $time, e.value, v);
        fails++;
      end
      if (run_end !== e.run_end) begin
        $display("%0t: run_last mismatch: expected %b, got %b", $time, e.run_end, run_end);
        fails++;
      end
      if (list_end !== e.list_end) begin
        $display("%0t: list_done mismatch: expected %b, got %b",
                 $time, e.list_end, list_end);
        fails++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] elem_value
  logic        s_axis_tlast = 1'b0; // list_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] out_value
  logic        m_axis_tlast;        // run_last
  logic        m_axis_tuser;        // [0] list_done

  group_reversal_model sb = new();

  int unsigned cycle_cnt = 0;
  int unsigned req_count = 0;
  logic        src_steady = 1'b0;   // input side sends back to back
  logic        sink_steady = 1'b0;  // output side never stalls

  k_group_order_reverser_unit #(
    .MAX_GROUP  (16),
    .VALUE_WIDTH(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // 2 ns period
  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // output side: random stall before each request, check on acceptance
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    forever begin
      gap = sink_steady ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      // ready stays up until the next negedge, so one request is taken here
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // --------------------------------------------------------------------------
  // input side tasks
  // --------------------------------------------------------------------------

  // one input request; valid is left high so a back-to-back request follows
  // without a drop, the next call changes it at the coming negedge
  task automatic send_elem(input logic [15:0] v, input logic ends);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= ends;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(v, ends);
    req_count++;
  endtask

  // a run of random values, list end optionally on the final one
  task automatic send_run(input int unsigned count, input logic with_end);
    logic [15:0] v;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       v = 16'h0000;
        1:       v = 16'hFFFF;
        default: v = 16'($urandom());
      endcase
      send_elem(v, with_end && (i + 1 == count));
    end
  endtask

  // group size write, only once every predicted result has been taken
  task automatic write_group_size(input logic [4:0] v);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_group_size(v);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0]  gs;
    int unsigned lists;
    int unsigned len;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset group size passes straight through
    send_elem(16'h0000, 1'b0);
    send_elem(16'hFFFF, 1'b1);
    // full group landing on the list end
    write_group_size(5'd4);
    send_elem(16'hFFFF, 1'b0);
    send_elem(16'h0000, 1'b0);
    send_elem(16'hAAAA, 1'b0);
    send_elem(16'h5555, 1'b1);
    // list shorter than the group: unchanged
    send_elem(16'h8001, 1'b1);
    // size lowered with elements already buffered: whole run out reversed
    write_group_size(5'd8);
    send_run(3, 1'b0);
    write_group_size(5'd2);
    send_elem(16'h7FFE, 1'b0);
    // zero size behaves as one
    write_group_size(5'd0);
    send_elem(16'h1234, 1'b1);
    // oversize saturates to the maximum group
    write_group_size(5'd31);
    send_run(MaxGroup, 1'b1);

    // random phases: a size per phase, a few lists, sometimes ending mid-list
    while (req_count < RandReqs) begin
      case ($urandom_range(0, 7))
        0:       gs = 5'd1;
        1:       gs = 5'd16;
        2:       gs = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
        default: gs = 5'($urandom_range(2, 15));
      endcase
      write_group_size(gs);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      lists = $urandom_range(1, 3);
      for (int unsigned l = 0; l < lists; l++) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        send_run(len, 1'b1);
      end
      if ($urandom_range(0, 2) == 0) send_run($urandom_range(1, 15), 1'b0);
    end
    send_run(1, 1'b1);

    // drain and let the block settle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0 && sb.due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
